// ----- design/pfcu_pkg.sv -----
// shared types and constants for the pcm frame converter / upsampler
// no dependencies; imported by every design file
package pfcu_pkg;

  // sample and configuration port widths
  localparam int unsigned SampleW  = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 4;

  // register codes and special values
  localparam logic [1:0] SampleBytes8 = 2'd1;
  localparam logic [1:0] ChannelsMono = 2'd1;
  localparam logic [1:0] PhaseDrop    = 2'd2;
  localparam logic [7:0] ByteBias     = 8'h80;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SAMPLE_BYTES  = 2'd0,
    CFG_CHANNEL_COUNT = 2'd1,
    CFG_REPEAT_FACTOR = 2'd2,
    CFG_FAST_MODE     = 2'd3
  } cfg_idx_e;

  // configuration register set
  typedef struct packed {
    logic [1:0] sample_bytes;
    logic [1:0] channel_count;
    logic [3:0] repeat_factor;
    logic       fast_mode;
  } cfg_t;

  // converted stereo frame
  typedef struct packed {
    logic signed [SampleW-1:0] left;
    logic signed [SampleW-1:0] right;
  } frame_t;

endpackage

// ----- design/pfcu_in_if.sv -----
// source frame request channel: valid/ready with two raw samples
// depends on pfcu_pkg
interface pfcu_in_if
  import pfcu_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] first_sample;
  logic [SampleW-1:0] second_sample;

  modport source (output valid, output first_sample, output second_sample, input ready);
  modport sink   (input valid, input first_sample, input second_sample, output ready);
endinterface

// ----- design/pfcu_out_if.sv -----
// output frame request channel: valid/ready with signed stereo samples
// depends on pfcu_pkg
interface pfcu_out_if
  import pfcu_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] left_out;
  logic signed [SampleW-1:0] right_out;
  logic                      run_last;

  modport source (output valid, output left_out, output right_out, output run_last,
                  input ready);
  modport sink   (input valid, input left_out, input right_out, input run_last,
                  output ready);
endinterface

// ----- design/pfcu_cfg_regs.sv -----
// configuration register file written through a plain write port
// depends on pfcu_pkg
module pfcu_cfg_regs
  import pfcu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SAMPLE_BYTES:  cfg_d.sample_bytes  = cfg_data_i[1:0];
        CFG_CHANNEL_COUNT: cfg_d.channel_count = cfg_data_i[1:0];
        CFG_REPEAT_FACTOR: cfg_d.repeat_factor = cfg_data_i[3:0];
        CFG_FAST_MODE:     cfg_d.fast_mode     = cfg_data_i[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_bytes  <= 2'd2;
      cfg_q.channel_count <= 2'd2;
      cfg_q.repeat_factor <= 4'd1;
      cfg_q.fast_mode     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/pfcu_convert.sv -----
// input stage: frame drop, sample widening, mono copy, repeat count
// depends on pfcu_pkg
module pfcu_convert
  import pfcu_pkg::*;
#(
  parameter int unsigned MAX_REPEAT = 8,
  localparam int unsigned RepW = $clog2(MAX_REPEAT + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SampleW-1:0] first_sample_i,
  input  logic [SampleW-1:0] second_sample_i,
  output logic               frm_valid_o,
  input  logic               frm_take_i,
  output frame_t             frm_o,
  output logic [RepW-1:0]    frm_reps_o
);

  logic            valid_q, valid_d;
  logic [1:0]      phase_q, phase_d;
  frame_t          frm_q, frm_d;
  logic [RepW-1:0] reps_q, reps_d;
  logic            accept;
  logic            drop;
  logic            eight_bit;
  logic [SampleW-1:0] left_w, right_w;

  assign in_ready_o = !valid_q || frm_take_i;
  assign accept     = in_valid_i && in_ready_o;
  assign drop       = cfg_i.fast_mode && (phase_q == PhaseDrop);
  assign eight_bit  = (cfg_i.sample_bytes == SampleBytes8);

  // widen 8-bit unsigned to signed 16-bit, copy mono to both sides
  always_comb begin
    left_w  = eight_bit ? {first_sample_i[7:0] ^ ByteBias, 8'h00} : first_sample_i;
    right_w = eight_bit ? {second_sample_i[7:0] ^ ByteBias, 8'h00} : second_sample_i;
    frm_d.left  = left_w;
    frm_d.right = (cfg_i.channel_count == ChannelsMono) ? left_w : right_w;
  end

  // repeat count: zero means one, saturate at the maximum
  always_comb begin
    if (cfg_i.repeat_factor == 4'd0) begin
      reps_d = RepW'(1);
    end else if (int'(cfg_i.repeat_factor) > int'(MAX_REPEAT)) begin
      reps_d = RepW'(MAX_REPEAT);
    end else begin
      reps_d = RepW'(cfg_i.repeat_factor);
    end
  end

  // frame index mod 3 advances on every request, dropped or not
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      phase_d = (phase_q >= 2'd2) ? 2'd0 : phase_q + 2'd1;
    end
  end

  // stage valid: loaded by a kept request, cleared when taken
  always_comb begin
    valid_d = valid_q;
    if (frm_take_i) begin
      valid_d = 1'b0;
    end
    if (accept && !drop) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 2'd0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (accept && !drop) begin
      frm_q  <= frm_d;
      reps_q <= reps_d;
    end
  end

  assign frm_valid_o = valid_q;
  assign frm_o       = frm_q;
  assign frm_reps_o  = reps_q;

endmodule

// ----- design/pfcu_repeat.sv -----
// output stage: holds one frame and emits it a counted number of times
// depends on pfcu_pkg
module pfcu_repeat
  import pfcu_pkg::*;
#(
  parameter int unsigned MAX_REPEAT = 8,
  localparam int unsigned RepW = $clog2(MAX_REPEAT + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      frm_valid_i,
  output logic                      frm_take_o,
  input  frame_t                    frm_i,
  input  logic [RepW-1:0]           frm_reps_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SampleW-1:0] left_out_o,
  output logic signed [SampleW-1:0] right_out_o,
  output logic                      run_last_o
);

  logic            valid_q, valid_d;
  logic [RepW-1:0] cnt_q, cnt_d;
  frame_t          frm_q;
  logic            out_fire;
  logic            last;

  assign last       = (cnt_q == RepW'(1));
  assign out_fire   = valid_q && out_ready_i;
  assign frm_take_o = frm_valid_i && (!valid_q || (out_fire && last));

  // remaining-repeat counter and valid
  always_comb begin
    valid_d = valid_q;
    cnt_d   = cnt_q;
    if (frm_take_o) begin
      valid_d = 1'b1;
      cnt_d   = frm_reps_i;
    end else if (out_fire) begin
      valid_d = !last;
      cnt_d   = cnt_q - RepW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  // held frame
  always_ff @(posedge clk_i) begin
    if (frm_take_o) begin
      frm_q <= frm_i;
    end
  end

  assign out_valid_o = valid_q;
  assign left_out_o  = frm_q.left;
  assign right_out_o = frm_q.right;
  assign run_last_o  = last;

endmodule

// ----- design/pcm_frame_converter_upsampler_top.sv -----
// top level of the pcm frame converter with zero-order-hold upsampling
// depends on pfcu_pkg, pfcu_in_if, pfcu_out_if, pfcu_cfg_regs, pfcu_convert, pfcu_repeat
//
// Usage:
//   in_if  : one source frame per request (first_sample, second_sample).
//   out_if : signed 16-bit stereo frames; run_last marks the final repeat
//            of a source frame.
//   cfg    : write cfg_we_i with cfg_idx_i/cfg_data_i while the block is idle
//            (0 sample_bytes, 1 channel_count, 2 repeat_factor, 3 fast_mode).
// Path: after its request is accepted, a source frame goes through the input
//   register, then the output register, before its first output frame is valid.
// Throughput: one output frame per cycle while out_if.ready is high; a kept
//   source frame is emitted repeat_factor times (1..MAX_REPEAT), counted by the
//   repeat counter of the output stage. Dropped frames in fast mode are taken
//   at the input and produce nothing. With a factor of one and out_if.ready
//   high a new source frame is taken every cycle.
// Reset: registers return to 16-bit stereo, factor 1, fast mode off; the
//   frame phase counter and both stages are cleared.
// Stall: while out_if.ready is low the output frame holds; the input stage
//   still takes requests until it holds a kept frame, then in_if.ready drops.
module pcm_frame_converter_upsampler_top
  import pfcu_pkg::*;
#(
  parameter int unsigned MAX_REPEAT = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  pfcu_in_if.sink             in_if,
  pfcu_out_if.source          out_if
);

  localparam int unsigned RepW = $clog2(MAX_REPEAT + 1);

  cfg_t            cfg;
  logic            frm_valid;
  logic            frm_take;
  frame_t          frm;
  logic [RepW-1:0] frm_reps;

  // configuration registers
  pfcu_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // input conversion stage
  pfcu_convert #(
    .MAX_REPEAT (MAX_REPEAT)
  ) u_convert (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_if.valid),
    .in_ready_o      (in_if.ready),
    .first_sample_i  (in_if.first_sample),
    .second_sample_i (in_if.second_sample),
    .frm_valid_o     (frm_valid),
    .frm_take_i      (frm_take),
    .frm_o           (frm),
    .frm_reps_o      (frm_reps)
  );

  // repeat and output stage
  pfcu_repeat #(
    .MAX_REPEAT (MAX_REPEAT)
  ) u_repeat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frm_valid_i (frm_valid),
    .frm_take_o  (frm_take),
    .frm_i       (frm),
    .frm_reps_i  (frm_reps),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .left_out_o  (out_if.left_out),
    .right_out_o (out_if.right_out),
    .run_last_o  (out_if.run_last)
  );

endmodule
